// ===== hw/rtl/rpbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpbr_pkg
// Shared types and constants for the range partition bucket router.
// ----------------------------------------------------------------------------
package rpbr_pkg;
  localparam int MaxBuckets   = 64;
  localparam int KeyWords     = 9;
  localparam int CountBits    = 40;
  localparam int KeyBytes     = 66;
  localparam int NumSplitters = MaxBuckets - 1;
  localparam int SplitDepth   = NumSplitters * KeyWords;
  localparam int SplitAw      = $clog2(SplitDepth);
  localparam int BAw          = $clog2(MaxBuckets);
  localparam int WAw          = $clog2(KeyWords + 1);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMP_EQUAL   = 2'd0,
    CMP_LESS    = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_t;

  typedef enum logic {
    KIND_ROUTE = 1'b0,
    KIND_COUNT = 1'b1
  } kind_t;

  // byte mask of the valid bytes of key word w
  function automatic logic [63:0] byte_mask(input logic [3:0] w);
    logic [63:0] m;
    int          first;
    first = int'(w) * 8;
    if (first >= KeyBytes) m = '0;
    else if (KeyBytes - first >= 8) m = '1;
    else m = ~(64'h0) << (64 - 8 * (KeyBytes - first));
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rpbr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpbr_req_if / rpbr_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rpbr_req_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  entry_index;
  logic [3:0]  word_index;
  logic [63:0] data_word;
  logic        last_word;
  modport source (output valid, mode, entry_index, word_index, data_word, last_word,
                  input ready);
  modport sink (input valid, mode, entry_index, word_index, data_word, last_word,
                output ready);
endinterface

interface rpbr_res_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [5:0]  bucket;
  logic [39:0] slot;
  logic [39:0] count_value;
  modport source (output valid, result_kind, bucket, slot, count_value, input ready);
  modport sink (input valid, result_kind, bucket, slot, count_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/range_partition_bucket_router_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_partition_bucket_router_top
// Routes streamed 66-byte keys to range buckets against loaded splitters.
// ----------------------------------------------------------------------------
// Key words and count reads pass through ST_IDLE, ST_RD and ST_WB: in ST_IDLE
// the request is taken and the splitter row for the current key word (one row
// of 63 splitter words per key word) is read; in ST_RD all 63 splitter cells
// compare in parallel and the bucket counter is read; in ST_WB the compare
// states and the counter are written back and the result register is loaded,
// waiting only if it must load a result while the last one is still unread;
// then the next request is taken. Splitter loads are written as they are
// taken and can follow back to back. A clear sweeps the 64-entry counter
// memory, one entry a cycle, before the next request is taken; the same sweep
// runs after reset. A result waiting in the output register does not hold off
// requests; only the completion of the next key end or count read waits.
module range_partition_bucket_router_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [6:0] cfg_wdata,
  rpbr_req_if.sink   req,
  rpbr_res_if.source res
);
  import rpbr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WB, ST_CLEAR} state_t;

  state_t state;
  logic [6:0] num_buckets;
  logic [1:0] cmp_st [NumSplitters];
  logic [WAw-1:0] key_cnt;
  logic [BAw:0] clr_idx;

  // latched request
  logic [1:0]  r_mode;
  logic [5:0]  r_entry;
  logic [63:0] r_data;
  logic        r_last;
  logic [BAw-1:0] b_q;

  // splitter memory: row = key word, column = splitter
  logic [NumSplitters-1:0][63:0] split_mem [KeyWords];
  logic [NumSplitters-1:0][63:0] split_row;
  logic [CountBits-1:0] cnt_mem [MaxBuckets];
  logic [CountBits-1:0] cnt_q;

  logic acc;
  logic res_need;
  logic wb_go;
  logic cnt_wr;
  assign req.ready = (state == ST_IDLE);
  assign acc = req.valid && req.ready;

  // write-back waits only when it must load a result over a waiting one
  assign res_need = (r_mode == MODE_READ) || r_last;
  assign wb_go = (state == ST_WB) && (!res_need || !res.valid || res.ready);

  logic [WAw-1:0] rd_row;
  assign rd_row = (key_cnt < WAw'(KeyWords)) ? key_cnt : '0;

  always_ff @(posedge clk) begin
    if (acc) split_row <= split_mem[rd_row[3:0]];
    if (acc && req.mode == MODE_LOAD && int'(req.entry_index) < NumSplitters
        && int'(req.word_index) < KeyWords)
      split_mem[req.word_index][req.entry_index] <= req.data_word;
  end

  // bucket choice from compare states after this word
  logic [1:0] cmp_new [NumSplitters];
  logic [63:0] km;
  logic do_cmp;
  logic [6:0] k_act;
  logic [BAw-1:0] bsel;
  always_comb begin
    do_cmp = (key_cnt < WAw'(KeyWords));
    km = byte_mask(4'(key_cnt)) & r_data;
    k_act = (num_buckets < 7'd2) ? 7'd2 :
            (num_buckets > 7'(MaxBuckets)) ? 7'(MaxBuckets) : num_buckets;
    for (int s = 0; s < NumSplitters; s++) begin
      logic [63:0] sp;
      sp = split_row[s] & byte_mask(4'(key_cnt));
      cmp_new[s] = cmp_st[s];
      if (do_cmp && cmp_st[s] == CMP_EQUAL && km != sp)
        cmp_new[s] = (km < sp) ? CMP_LESS : CMP_GREATER;
    end
    bsel = BAw'(k_act - 7'd1);
    for (int s = NumSplitters - 1; s >= 0; s--)
      if (s + 1 < int'(k_act) && cmp_new[s] != CMP_GREATER) bsel = BAw'(s);
  end

  // counter read address: bucket of key or read entry
  logic [BAw-1:0] cnt_addr;
  assign cnt_addr = (r_mode == MODE_KEY) ? bsel : r_entry;
  assign cnt_wr = wb_go && (r_mode == MODE_KEY) && r_last && (cnt_q != '1);

  // counter memory: read in the compare cycle, written back after it
  always_ff @(posedge clk) begin
    if (state == ST_RD) cnt_q <= cnt_mem[cnt_addr];
    if (state == ST_CLEAR) cnt_mem[clr_idx[BAw-1:0]] <= '0;
    else if (cnt_wr) cnt_mem[b_q] <= cnt_q + 1'b1;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      key_cnt <= '0;
      res.valid <= 1'b0;
      for (int s = 0; s < NumSplitters; s++) cmp_st[s] <= CMP_EQUAL;
    end else begin
      if (wb_go && res_need) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            r_mode <= req.mode; r_entry <= req.entry_index;
            r_data <= req.data_word; r_last <= req.last_word;
            if (req.mode == MODE_CLEAR) begin
              state <= ST_CLEAR; clr_idx <= '0;
            end else if (req.mode == MODE_LOAD) state <= ST_IDLE;
            else state <= ST_RD;
          end
        end
        ST_RD: begin
          b_q <= bsel;
          state <= ST_WB;
        end
        ST_WB: begin
          if (wb_go) begin
            state <= ST_IDLE;
            if (r_mode == MODE_READ) begin
              res.result_kind <= KIND_COUNT;
              res.bucket <= r_entry; res.slot <= '0; res.count_value <= cnt_q;
            end else if (r_last) begin
              res.result_kind <= KIND_ROUTE;
              res.bucket <= b_q; res.slot <= cnt_q; res.count_value <= '0;
              key_cnt <= '0;
              for (int s = 0; s < NumSplitters; s++) cmp_st[s] <= CMP_EQUAL;
            end else begin
              if (do_cmp) key_cnt <= key_cnt + 1'b1;
              for (int s = 0; s < NumSplitters; s++) cmp_st[s] <= cmp_new[s];
            end
          end
        end
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (BAw+1)'(MaxBuckets - 1)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) num_buckets <= 7'd2;
    else if (cfg_we) num_buckets <= cfg_wdata;
  end

`ifndef SYNTH
  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !req.ready) else $error("request taken while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    key_cnt <= WAw'(KeyWords)) else $error("key word count overrun");
  a_res_kind: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.result_kind == KIND_COUNT |-> res.slot == '0)
    else $error("count read with slot");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.bucket) && $stable(res.slot))
    else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

// ===== sim/range_partition_bucket_router_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_partition_bucket_router_top_test
// Drives splitter loads, keys, count reads and clears into the bucket router
// and checks every result against a behavioural predictor of the routing.
// ----------------------------------------------------------------------------
module range_partition_bucket_router_top_test;
  import rpbr_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [5:0]  entry_index;
    logic [3:0]  word_index;
    logic [63:0] data_word;
    logic        last_word;
  } request_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  bucket;
    logic [39:0] slot;
    logic [39:0] count_value;
  } routing_t;

  localparam int CycleLimit = 400000;
  localparam logic [39:0] CountFull = {40{1'b1}};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  rpbr_req_if req (.clk(clk));
  rpbr_res_if res (.clk(clk));

  range_partition_bucket_router_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .res(res.source)
  );

  // predictor state
  logic [63:0] split_mem [NumSplitters][KeyWords];
  cmp_t        key_cmp [NumSplitters];
  int          key_words_seen;
  logic [39:0] bucket_tally [MaxBuckets];
  logic [6:0]  bucket_reg;

  request_t pending_requests[$];
  routing_t expected_routes[$];
  int       error_count;
  int       cycle_count;
  bit       driving_done;
  bit       idle_free;
  bit       hold_start;
  bit       holding;
  bit       req_taken;
  int       src_gap;
  int       snk_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // routing predictor, applied to each accepted request
  task automatic predict_routing(input request_t r);
    routing_t    o;
    logic [63:0] m;
    logic [63:0] sp;
    int          k_act;
    int          b;
    case (r.mode)
      MODE_LOAD: begin
        if (r.entry_index < NumSplitters && r.word_index < KeyWords)
          split_mem[r.entry_index][r.word_index] = r.data_word;
      end
      MODE_CLEAR: begin
        foreach (bucket_tally[i]) bucket_tally[i] = '0;
      end
      MODE_READ: begin
        o.kind = KIND_COUNT;
        o.bucket = r.entry_index;
        o.slot = '0;
        o.count_value = bucket_tally[r.entry_index];
        expected_routes.push_back(o);
      end
      default: begin
        if (key_words_seen < KeyWords) begin
          m = '1;
          if (key_words_seen * 8 >= KeyBytes) m = '0;
          else if (KeyBytes - key_words_seen * 8 < 8)
            m = m << (64 - 8 * (KeyBytes - key_words_seen * 8));
          for (int s = 0; s < NumSplitters; s++) begin
            sp = split_mem[s][key_words_seen] & m;
            if (key_cmp[s] == CMP_EQUAL && (r.data_word & m) != sp)
              key_cmp[s] = ((r.data_word & m) < sp) ? CMP_LESS : CMP_GREATER;
          end
          key_words_seen++;
        end
        if (r.last_word) begin
          k_act = bucket_reg < 2 ? 2 : (bucket_reg > MaxBuckets ? MaxBuckets : bucket_reg);
          b = k_act - 1;
          for (int s = 0; s + 1 < k_act; s++) begin
            if (key_cmp[s] != CMP_GREATER) begin
              b = s;
              break;
            end
          end
          o.kind = KIND_ROUTE;
          o.bucket = b[5:0];
          o.slot = bucket_tally[b];
          o.count_value = '0;
          if (bucket_tally[b] != CountFull) bucket_tally[b]++;
          foreach (key_cmp[i]) key_cmp[i] = CMP_EQUAL;
          key_words_seen = 0;
          expected_routes.push_back(o);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic request_t make_req(input mode_t md, input int ent, input int wi,
                                        input logic [63:0] d, input bit lst);
    request_t r;
    r.mode = md;
    r.entry_index = ent[5:0];
    r.word_index = wi[3:0];
    r.data_word = d;
    r.last_word = lst;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // requests taken at the rising edge, seen by the sender
  always @(posedge clk) req_taken <= req.valid && req.ready;

  // sender: present the next pending request at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_taken) begin
      req.valid <= 1'b1;
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      req.valid <= 1'b0;
    end else if (pending_requests.size() > 0) begin
      {req.mode, req.entry_index, req.word_index, req.data_word, req.last_word}
        <= pending_requests.pop_front();
      req.valid <= 1'b1;
      if (!idle_free && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 5);
    end else begin
      req.valid <= 1'b0;
    end
  end

  // long receiver hold-off, counted here once started
  initial begin
    holding = 1'b0;
    wait (hold_start);
    @(negedge clk);
    holding <= 1'b1;
    repeat (300) @(negedge clk);
    holding <= 1'b0;
  end

  // receiver readiness with random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (holding) begin
      res.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      res.ready <= 1'b0;
    end else if (!idle_free && $urandom_range(0, 7) == 0) begin
      snk_gap <= $urandom_range(0, 4);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    routing_t got;
    routing_t want;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (req.valid && req.ready)
        predict_routing({req.mode, req.entry_index, req.word_index, req.data_word,
                         req.last_word});
      if (res.valid && res.ready) begin
        got = {res.result_kind, res.bucket, res.slot, res.count_value};
        if (expected_routes.size() == 0) begin
          report_mismatch("unexpected result", 64'(got.bucket), 64'h0);
        end else begin
          want = expected_routes.pop_front();
          if (got.kind != want.kind)
            report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
          if (got.bucket != want.bucket)
            report_mismatch("bucket", 64'(got.bucket), 64'(want.bucket));
          if (got.slot != want.slot)
            report_mismatch("slot", 64'(got.slot), 64'(want.slot));
          if (got.count_value != want.count_value)
            report_mismatch("count_value", 64'(got.count_value), 64'(want.count_value));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_routes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || req.valid || expected_routes.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [6:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    bucket_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // full splitter set; first words ascending if asked, so routes spread over buckets
  task automatic load_splitters(input bit ascending);
    logic [63:0] w;
    for (int s = 0; s < NumSplitters; s++)
      for (int wi = 0; wi < KeyWords; wi++) begin
        w = ascending && wi == 0 ? {s[5:0] + 6'd1, 58'h0} | (rand_word() >> 6)
                                 : rand_word();
        pending_requests.push_back(make_req(MODE_LOAD, s, wi, w, 1'b0));
      end
  endtask

  // one key, close to a chosen splitter so later words decide
  task automatic push_key(input int near, input int nwords);
    logic [63:0] w;
    for (int wi = 0; wi < nwords; wi++) begin
      if (wi < KeyWords && $urandom_range(0, 3) != 0) w = split_mem[near][wi];
      else w = rand_word();
      if (wi < KeyWords && $urandom_range(0, 9) == 0) w = w ^ (64'h1 << $urandom_range(0, 63));
      pending_requests.push_back(make_req(MODE_KEY, 0, 0, w, wi == nwords - 1));
    end
  endtask

  // random mix of keys, count reads, splitter loads and clears until n is reached
  task automatic random_phase(input int n);
    int cnt;
    int r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_key($urandom_range(0, NumSplitters - 1),
                 $urandom_range(0, 4) == 0 ? $urandom_range(1, 12) : KeyWords);
        cnt += KeyWords;
      end else if (r < 85) begin
        pending_requests.push_back(make_req(MODE_READ, $urandom_range(0, 63), 0, rand_word(),
                                            1'($urandom_range(0, 1))));
        cnt++;
      end else if (r < 97) begin
        pending_requests.push_back(make_req(MODE_LOAD, $urandom_range(0, 63),
                                            $urandom_range(0, 15), rand_word(), 1'b0));
        cnt++;
      end else begin
        pending_requests.push_back(make_req(MODE_CLEAR, $urandom_range(0, 63),
                                            $urandom_range(0, 15), rand_word(), 1'b0));
        cnt++;
      end
    end
  endtask

  initial begin
    logic [6:0] k_settings [6] = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd17, 7'd65};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.mode = MODE_LOAD;
    req.entry_index = '0;
    req.word_index = '0;
    req.data_word = '0;
    req.last_word = 1'b0;
    res.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    driving_done = 0;
    idle_free = 0;
    hold_start = 0;
    src_gap = 0;
    snk_gap = 0;
    bucket_reg = 7'd2;
    key_words_seen = 0;
    foreach (key_cmp[i]) key_cmp[i] = CMP_EQUAL;
    foreach (bucket_tally[i]) bucket_tally[i] = '0;
    foreach (split_mem[i, j]) split_mem[i][j] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every splitter written first, then edge cases
    load_splitters(1'b1);
    wait_drained();
    write_buckets(7'd64);
    pending_requests.push_back(make_req(MODE_KEY, 0, 0, 64'h0, 1'b1));
    for (int wi = 0; wi < 12; wi++)
      pending_requests.push_back(make_req(MODE_KEY, 63, 15, '1, wi == 11));
    for (int wi = 0; wi < KeyWords; wi++)
      pending_requests.push_back(make_req(MODE_KEY, 0, 0, split_mem[5][wi] ^
                                          (wi == 8 ? 64'h0000_FFFF_FFFF_FFFF : 64'h0),
                                          wi == KeyWords - 1));
    pending_requests.push_back(make_req(MODE_LOAD, 63, 0, '1, 1'b0));
    pending_requests.push_back(make_req(MODE_LOAD, 3, 9, '1, 1'b0));
    pending_requests.push_back(make_req(MODE_LOAD, 3, 15, '1, 1'b0));
    pending_requests.push_back(make_req(MODE_READ, 0, 0, 64'h0, 1'b0));
    pending_requests.push_back(make_req(MODE_READ, 63, 15, '1, 1'b1));
    pending_requests.push_back(make_req(MODE_CLEAR, 0, 0, 64'h0, 1'b0));
    pending_requests.push_back(make_req(MODE_READ, 63, 0, 64'h0, 1'b0));
    wait_drained();

    // long receiver hold-off while keys keep coming
    hold_start = 1'b1;
    random_phase(100);
    wait_drained();

    // random phases across bucket settings; one reload of unsorted splitters
    foreach (k_settings[i]) begin
      write_buckets(k_settings[i]);
      if (i == 3) begin
        load_splitters(1'b0);
        pending_requests.push_back(make_req(MODE_CLEAR, 0, 0, 64'h0, 1'b0));
      end
      if (i == 5) idle_free = 1;
      random_phase(100);
      wait_drained();
    end

    $display("covered splitter loads including out of range, full and short keys,");
    $display("count reads and clears over bucket settings 0 to 127, with stalls");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
